// ===== rtl/ppe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool engine package
// Pool sizing, grid limits, operation codes and the slot record shared by the
// slot cells, the head update unit and the top level.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int POOL_SLOTS   = 32;
  localparam int GRID_COLUMNS = 64;
  localparam int GRID_ROWS    = 32;
  localparam int MAX_RESULTS  = 32;

  // results emitted per tick
  localparam int NRES  = (POOL_SLOTS < MAX_RESULTS) ? POOL_SLOTS : MAX_RESULTS;
  localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

  // grid limits in Q8.8
  localparam logic [15:0] COL_LIMIT = 16'(GRID_COLUMNS * 256);
  localparam logic [15:0] ROW_LIMIT = 16'(GRID_ROWS * 256);

  localparam logic [20:0]        TIMER_MAX    = 21'h1FFFFF;
  localparam logic signed [20:0] PERIOD_NEVER = -21'sd1;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  typedef struct packed {
    logic               live;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] spd_x;
    logic signed [15:0] spd_y;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic [7:0]         glyph0;
    logic [7:0]         glyph1;
    logic               phase;
    logic signed [20:0] period;
    logic [20:0]        timer;
  } slot_t;

  // latched input transaction
  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic [7:0]         first_glyph;
    logic [7:0]         second_glyph;
    logic               start_phase;
    logic signed [20:0] anim_period;
    logic [19:0]        frame_time;
  } item_t;

  typedef struct packed {
    logic tick;   // 1: tick walk, 0: insert walk
    logic found;  // insert already placed earlier in this walk
  } upd_ctl_t;

  typedef struct packed {
    logic               take;
    logic               alive;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         glyph;
  } upd_res_t;

endpackage

// ===== rtl/ppe_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool slot cell
// Holds one slot record and takes its neighbor's record on every shift.
// ----------------------------------------------------------------------------
module ppe_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  logic          clr,
  input  ppe_pkg::slot_t din,
  output ppe_pkg::slot_t dout
);
  import ppe_pkg::*;

  slot_t rec;
  logic  live;

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (clr) begin
      live <= 1'b0;
    end else if (shift) begin
      live <= din.live;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      rec <= din;
    end
  end

  always_comb begin
    dout      = rec;
    dout.live = live;
  end

endmodule

// ===== rtl/ppe_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool head update
// Computes the new record and the result for the slot at the head of the
// ring: motion, grid test and animation timer for a tick, placement for an
// insert.
// ----------------------------------------------------------------------------
module ppe_update (
  input  ppe_pkg::slot_t    head,
  input  ppe_pkg::item_t    item,
  input  ppe_pkg::upd_ctl_t ctl,
  output ppe_pkg::slot_t    rec_next,
  output ppe_pkg::upd_res_t res
);
  import ppe_pkg::*;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v[16] != v[15]) begin
      r = v[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic signed [15:0] sx, sy;
  logic signed [16:0] nx, ny;
  logic               off_grid;
  logic [21:0]        tsum;
  logic [20:0]        tsat;
  logic signed [22:0] tdiff;
  logic               toggle;
  logic [20:0]        tnew;
  logic               phase_new;

  assign sx = sat16({head.spd_x[15], head.spd_x} + {head.acc_x[15], head.acc_x});
  assign sy = sat16({head.spd_y[15], head.spd_y} + {head.acc_y[15], head.acc_y});
  assign nx = {head.pos_x[15], head.pos_x} + {sx[15], sx};
  assign ny = {head.pos_y[15], head.pos_y} + {sy[15], sy};

  assign off_grid = nx[16] || (nx[15:0] >= COL_LIMIT) ||
                    ny[16] || (ny[15:0] >= ROW_LIMIT);

  // timer add saturates, then a negative period adds its magnitude
  assign tsum   = {1'b0, head.timer} + {2'b00, item.frame_time};
  assign tsat   = tsum[21] ? TIMER_MAX : tsum[20:0];
  assign tdiff  = $signed({2'b00, tsat}) - {{2{head.period[20]}}, head.period};
  assign toggle = (head.period != PERIOD_NEVER) && !tdiff[22];
  assign tnew   = !toggle ? tsat : (tdiff[21] ? TIMER_MAX : tdiff[20:0]);
  assign phase_new = head.phase ^ toggle;

  always_comb begin
    rec_next = head;
    res      = '0;
    if (ctl.tick) begin
      if (head.live) begin
        rec_next.spd_x = sx;
        rec_next.spd_y = sy;
        if (off_grid) begin
          rec_next.live = 1'b0;
        end else begin
          rec_next.pos_x = nx[15:0];
          rec_next.pos_y = ny[15:0];
          rec_next.timer = tnew;
          rec_next.phase = phase_new;
          res.alive      = 1'b1;
          res.x          = nx[15:0];
          res.y          = ny[15:0];
          res.glyph      = phase_new ? head.glyph1 : head.glyph0;
        end
      end
    end else if (!ctl.found && !head.live) begin
      res.take        = 1'b1;
      res.alive       = 1'b1;
      res.x           = item.start_x;
      res.y           = item.start_y;
      res.glyph       = item.start_phase ? item.second_glyph : item.first_glyph;
      rec_next.live   = 1'b1;
      rec_next.pos_x  = item.start_x;
      rec_next.pos_y  = item.start_y;
      rec_next.spd_x  = item.vel_x;
      rec_next.spd_y  = item.vel_y;
      rec_next.acc_x  = item.acc_x;
      rec_next.acc_y  = item.acc_y;
      rec_next.glyph0 = item.first_glyph;
      rec_next.glyph1 = item.second_glyph;
      rec_next.phase  = item.start_phase;
      rec_next.period = item.anim_period;
      rec_next.timer  = '0;
    end
  end

endmodule

// ===== rtl/particle_pool_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool engine
// Fixed pool of particle slots held in a ring of cells with one update unit.
// ----------------------------------------------------------------------------
// The slots sit in a ring of POOL_SLOTS cells; insert and tick rotate the ring
// once, one slot per cycle while the output register is free, through a single
// update unit at the head. Each is taken in an idle cycle and then walks all
// POOL_SLOTS slots; a stalled output holds the walk. A clear is taken in an idle
// cycle and clears all slots once the output is free; an unknown op is taken
// and dropped. A new transaction is taken once the previous walk is done, while
// its last result may still wait in the output register. A tick gives one
// result per slot for the first 32 slots; an insert or a clear gives one result.
module particle_pool_engine_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] acc_x,
  input  logic signed [15:0] acc_y,
  input  logic [7:0]         first_glyph,
  input  logic [7:0]         second_glyph,
  input  logic               start_phase,
  input  logic signed [20:0] anim_period,
  input  logic [19:0]        frame_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         slot_index,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic [7:0]         glyph,
  output logic               alive,
  output logic               accepted,
  output logic               last
);
  import ppe_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CLEAR  = 4'b0010,
    ST_INSERT = 4'b0100,
    ST_TICK   = 4'b1000
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] cnt;
  logic             found;
  item_t            item;

  logic     in_acc, out_free, step, at_last, clr_all, emit;
  logic     emit_tick, tick_last;
  upd_ctl_t ctl;
  slot_t    upd_rec;
  upd_res_t res;
  slot_t    cell_q [POOL_SLOTS];
  slot_t    cell_d [POOL_SLOTS];

  logic [4:0]         e_index;
  logic signed [15:0] e_x, e_y;
  logic [7:0]         e_glyph;
  logic               e_alive, e_acc, e_last;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign step     = out_free && ((state == ST_INSERT) || (state == ST_TICK));
  assign clr_all  = out_free && (state == ST_CLEAR);
  assign at_last  = (cnt == IDX_W'(POOL_SLOTS - 1));

  assign emit_tick = ({1'b0, cnt} < (IDX_W + 1)'(NRES));
  assign tick_last = (cnt == IDX_W'(NRES - 1));

  assign ctl.tick  = (state == ST_TICK);
  assign ctl.found = found;

  // ring: head is cell 0, the updated head record enters at the tail
  for (genvar i = 0; i < POOL_SLOTS; i++) begin : g_cell
    if (i == POOL_SLOTS - 1) begin : g_tail
      assign cell_d[i] = upd_rec;
    end else begin : g_link
      assign cell_d[i] = cell_q[i + 1];
    end
    ppe_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .shift(step),
      .clr  (clr_all),
      .din  (cell_d[i]),
      .dout (cell_q[i])
    );
  end

  ppe_update u_update (
    .head    (cell_q[0]),
    .item    (item),
    .ctl     (ctl),
    .rec_next(upd_rec),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      found <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          cnt   <= '0;
          found <= 1'b0;
          if (in_acc) begin
            case (op)
              OP_CLEAR:  state <= ST_CLEAR;
              OP_INSERT: state <= ST_INSERT;
              OP_TICK:   state <= ST_TICK;
              default:   state <= ST_IDLE;
            endcase
          end
        end
        ST_CLEAR: begin
          if (out_free) state <= ST_IDLE;
        end
        ST_INSERT, ST_TICK: begin
          if (step) begin
            cnt <= at_last ? '0 : cnt + 1'b1;
            if (res.take) found <= 1'b1;
            if (at_last) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item.start_x      <= start_x;
      item.start_y      <= start_y;
      item.vel_x        <= vel_x;
      item.vel_y        <= vel_y;
      item.acc_x        <= acc_x;
      item.acc_y        <= acc_y;
      item.first_glyph  <= first_glyph;
      item.second_glyph <= second_glyph;
      item.start_phase  <= start_phase;
      item.anim_period  <= anim_period;
      item.frame_time   <= frame_time;
    end
  end

  always_comb begin
    emit    = 1'b0;
    e_index = 5'(cnt);
    e_x     = res.x;
    e_y     = res.y;
    e_glyph = res.glyph;
    e_alive = res.alive;
    e_acc   = 1'b1;
    e_last  = 1'b1;
    case (state)
      ST_CLEAR: begin
        emit    = out_free;
        e_index = '0;
        e_x     = '0;
        e_y     = '0;
        e_glyph = '0;
        e_alive = 1'b0;
      end
      ST_INSERT: begin
        emit = step && (res.take || (at_last && !found));
        if (!res.take) begin
          // pool full
          e_index = '0;
          e_acc   = 1'b0;
        end
      end
      ST_TICK: begin
        emit   = step && emit_tick;
        e_last = tick_last;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      slot_index <= e_index;
      out_x      <= e_x;
      out_y      <= e_y;
      glyph      <= e_glyph;
      alive      <= e_alive;
      accepted   <= e_acc;
      last       <= e_last;
    end
  end

endmodule

// ===== rtl/ppe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool engine port checker
// Watches the top level ports for result consistency and output hold.
// ----------------------------------------------------------------------------
module ppe_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [4:0]         slot_index,
  input logic signed [15:0] out_x,
  input logic signed [15:0] out_y,
  input logic [7:0]         glyph,
  input logic               alive,
  input logic               accepted,
  input logic               last
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(slot_index) && $stable(out_x) &&
      $stable(out_y) && $stable(glyph) && $stable(alive) && $stable(last))
    else $error("stalled result changed");

  // free slot reports all zero
  a_dead_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !alive |-> out_x == 16'sd0 && out_y == 16'sd0 && glyph == 8'd0)
    else $error("dead slot with nonzero payload");

  // rejected insert is a lone final result with slot zero
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> !alive && last && slot_index == 5'd0)
    else $error("bad rejected insert result");

  // live particle only comes from an accepted transaction
  a_alive_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid && alive |-> accepted)
    else $error("live result not accepted");

endmodule

bind particle_pool_engine_unit ppe_checker u_ppe_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .slot_index(slot_index),
  .out_x     (out_x),
  .out_y     (out_y),
  .glyph     (glyph),
  .alive     (alive),
  .accepted  (accepted),
  .last      (last)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool engine testbench
// Drives clear, insert, tick and unknown transactions into the engine with
// random idle bursts on both sides and one long output hold-off. A shadow
// copy of the particle pool predicts every result, and each result is checked
// field by field in order as it arrives.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam longint     TIMER_CAP  = longint'(ppe_pkg::TIMER_MAX);
  localparam int         N_RANDOM   = 450;
  localparam int         QUIET_TAIL = 60;

  typedef struct packed {
    logic [1:0]     op;
    ppe_pkg::item_t f;
  } particle_cmd_t;

  typedef struct packed {
    logic [4:0]  slot;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  glyph;
    logic        alive;
    logic        accepted;
    logic        last;
  } particle_result_t;

  class particle_pool_shadow;
    particle_result_t   slot_reports_due[$];
    int                 errors;
    logic               live   [ppe_pkg::POOL_SLOTS];
    logic signed [15:0] pos_x  [ppe_pkg::POOL_SLOTS];
    logic signed [15:0] pos_y  [ppe_pkg::POOL_SLOTS];
    logic signed [15:0] spd_x  [ppe_pkg::POOL_SLOTS];
    logic signed [15:0] spd_y  [ppe_pkg::POOL_SLOTS];
    logic signed [15:0] acc_x  [ppe_pkg::POOL_SLOTS];
    logic signed [15:0] acc_y  [ppe_pkg::POOL_SLOTS];
    logic [7:0]         glyph0 [ppe_pkg::POOL_SLOTS];
    logic [7:0]         glyph1 [ppe_pkg::POOL_SLOTS];
    logic               phase  [ppe_pkg::POOL_SLOTS];
    logic signed [20:0] period [ppe_pkg::POOL_SLOTS];
    logic [20:0]        timer  [ppe_pkg::POOL_SLOTS];

    function new();
      errors = 0;
      foreach (live[i]) live[i] = 1'b0;
    endfunction

    function logic signed [15:0] sat_speed(int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
    endfunction

    // work out the results one accepted transaction causes
    function void apply_cmd(particle_cmd_t c);
      particle_result_t r;
      int               pick;
      int               nx;
      int               ny;
      longint           t;
      longint           p;
      r = '0;
      r.accepted = 1'b1;
      r.last = 1'b1;
      case (c.op)
        ppe_pkg::OP_CLEAR: begin
          foreach (live[i]) live[i] = 1'b0;
          slot_reports_due.push_back(r);
        end
        ppe_pkg::OP_INSERT: begin
          pick = -1;
          for (int i = 0; i < ppe_pkg::POOL_SLOTS; i++)
            if (!live[i] && pick < 0) pick = i;
          if (pick < 0) begin
            r.accepted = 1'b0;
          end else begin
            live[pick]   = 1'b1;
            pos_x[pick]  = c.f.start_x;
            pos_y[pick]  = c.f.start_y;
            spd_x[pick]  = c.f.vel_x;
            spd_y[pick]  = c.f.vel_y;
            acc_x[pick]  = c.f.acc_x;
            acc_y[pick]  = c.f.acc_y;
            glyph0[pick] = c.f.first_glyph;
            glyph1[pick] = c.f.second_glyph;
            phase[pick]  = c.f.start_phase;
            period[pick] = c.f.anim_period;
            timer[pick]  = '0;
            r.slot  = 5'(pick);
            r.x     = c.f.start_x;
            r.y     = c.f.start_y;
            r.glyph = c.f.start_phase ? c.f.second_glyph : c.f.first_glyph;
            r.alive = 1'b1;
          end
          slot_reports_due.push_back(r);
        end
        ppe_pkg::OP_TICK: begin
          for (int i = 0; i < ppe_pkg::POOL_SLOTS; i++) begin
            r = '0;
            r.slot = 5'(i);
            r.accepted = 1'b1;
            r.last = (i == ppe_pkg::NRES - 1);
            if (live[i]) begin
              spd_x[i] = sat_speed(int'(spd_x[i]) + int'(acc_x[i]));
              spd_y[i] = sat_speed(int'(spd_y[i]) + int'(acc_y[i]));
              nx = int'(pos_x[i]) + int'(spd_x[i]);
              ny = int'(pos_y[i]) + int'(spd_y[i]);
              if (nx < 0 || nx >= ppe_pkg::GRID_COLUMNS * 256 ||
                  ny < 0 || ny >= ppe_pkg::GRID_ROWS * 256) begin
                live[i] = 1'b0;
              end else begin
                t = longint'(timer[i]) + longint'(c.f.frame_time);
                p = longint'(period[i]);
                if (t > TIMER_CAP) t = TIMER_CAP;
                // negative periods other than never always count as reached
                if (period[i] != ppe_pkg::PERIOD_NEVER && t >= p) begin
                  phase[i] = ~phase[i];
                  t = t - p;
                  if (t > TIMER_CAP) t = TIMER_CAP;
                end
                timer[i] = t[20:0];
                pos_x[i] = nx[15:0];
                pos_y[i] = ny[15:0];
                r.x     = nx[15:0];
                r.y     = ny[15:0];
                r.glyph = phase[i] ? glyph1[i] : glyph0[i];
                r.alive = 1'b1;
              end
            end
            if (i < ppe_pkg::NRES) slot_reports_due.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void field_check(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_result(particle_result_t got);
      particle_result_t want;
      if (slot_reports_due.size() == 0) begin
        $display("%0t: unexpected result, expected none actual slot %0d x %h y %h",
                 $time, got.slot, got.x, got.y);
        errors++;
        return;
      end
      want = slot_reports_due.pop_front();
      field_check("slot_index", want.slot, got.slot);
      field_check("out_x", want.x, got.x);
      field_check("out_y", want.y, got.y);
      field_check("glyph", want.glyph, got.glyph);
      field_check("alive", want.alive, got.alive);
      field_check("accepted", want.accepted, got.accepted);
      field_check("last", want.last, got.last);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         op = ppe_pkg::OP_CLEAR;
  logic signed [15:0] start_x = '0;
  logic signed [15:0] start_y = '0;
  logic signed [15:0] vel_x = '0;
  logic signed [15:0] vel_y = '0;
  logic signed [15:0] acc_x = '0;
  logic signed [15:0] acc_y = '0;
  logic [7:0]         first_glyph = '0;
  logic [7:0]         second_glyph = '0;
  logic               start_phase = 1'b0;
  logic signed [20:0] anim_period = '0;
  logic [19:0]        frame_time = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [4:0]         slot_index;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic [7:0]         glyph;
  logic               alive;
  logic               accepted;
  logic               last;

  particle_pool_shadow pool = new();

  bit quiet = 1'b0;
  int n_accepted = 0;
  int calm_items = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_left = 0;
  int calm_left = 0;

  particle_pool_engine_unit i_dut (.*);

  always #10 clk = ~clk;

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  // every field random, including the ones the op ignores
  function automatic particle_cmd_t scrambled_cmd(logic [1:0] code);
    particle_cmd_t c;
    c.op             = code;
    c.f.start_x      = 16'($urandom);
    c.f.start_y      = 16'($urandom);
    c.f.vel_x        = 16'($urandom);
    c.f.vel_y        = 16'($urandom);
    c.f.acc_x        = 16'($urandom);
    c.f.acc_y        = 16'($urandom);
    c.f.first_glyph  = 8'($urandom);
    c.f.second_glyph = 8'($urandom);
    c.f.start_phase  = 1'($urandom);
    c.f.anim_period  = 21'($urandom);
    c.f.frame_time   = 20'($urandom);
    return c;
  endfunction

  function automatic particle_cmd_t particle(
      logic signed [15:0] x, logic signed [15:0] y,
      logic signed [15:0] vx, logic signed [15:0] vy,
      logic signed [15:0] ax, logic signed [15:0] ay,
      logic [7:0] g0, logic [7:0] g1, logic ph, logic signed [20:0] per);
    particle_cmd_t c;
    c = scrambled_cmd(ppe_pkg::OP_INSERT);
    c.f.start_x = x;
    c.f.start_y = y;
    c.f.vel_x = vx;
    c.f.vel_y = vy;
    c.f.acc_x = ax;
    c.f.acc_y = ay;
    c.f.first_glyph = g0;
    c.f.second_glyph = g1;
    c.f.start_phase = ph;
    c.f.anim_period = per;
    return c;
  endfunction

  function automatic particle_cmd_t tick_cmd(logic [19:0] ft);
    particle_cmd_t c;
    c = scrambled_cmd(ppe_pkg::OP_TICK);
    c.f.frame_time = ft;
    return c;
  endfunction

  // particle that stays on the grid for a while, random content
  function automatic particle_cmd_t drifting_insert();
    particle_cmd_t c;
    c = scrambled_cmd(ppe_pkg::OP_INSERT);
    c.f.start_x = 16'($urandom_range(0, 16383));
    c.f.start_y = 16'($urandom_range(0, 8191));
    c.f.vel_x = 16'(int'($urandom_range(0, 400)) - 200);
    c.f.vel_y = 16'(int'($urandom_range(0, 400)) - 200);
    c.f.acc_x = 16'(int'($urandom_range(0, 24)) - 12);
    c.f.acc_y = 16'(int'($urandom_range(0, 24)) - 12);
    case ($urandom_range(0, 4))
      0: c.f.anim_period = ppe_pkg::PERIOD_NEVER;
      1: c.f.anim_period = 21'($urandom_range(1, 50000));
      2: c.f.anim_period = 21'($urandom_range(0, 1048575));
      3: c.f.anim_period = 21'($urandom) | 21'h100000;
      default: c.f.anim_period = '0;
    endcase
    return c;
  endfunction

  function automatic particle_cmd_t random_tick();
    case ($urandom_range(0, 3))
      0: return tick_cmd('0);
      1: return tick_cmd(20'hFFFFF);
      2: return tick_cmd(20'($urandom_range(0, 40000)));
      default: return tick_cmd(20'($urandom));
    endcase
  endfunction

  task automatic send_cmd(input particle_cmd_t c);
    int gap;
    @(negedge clk);
    gap = 0;
    if (!quiet) begin
      if (calm_items > 0) calm_items--;
      else if ($urandom_range(0, 9) == 0) calm_items = $urandom_range(5, 30);
      else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 12);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op           <= c.op;
    start_x      <= c.f.start_x;
    start_y      <= c.f.start_y;
    vel_x        <= c.f.vel_x;
    vel_y        <= c.f.vel_y;
    acc_x        <= c.f.acc_x;
    acc_y        <= c.f.acc_y;
    first_glyph  <= c.f.first_glyph;
    second_glyph <= c.f.second_glyph;
    start_phase  <= c.f.start_phase;
    anim_period  <= c.f.anim_period;
    frame_time   <= c.f.frame_time;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pool.apply_cmd(c);
    n_accepted++;
  endtask

  // output side: random stall bursts, calm stretches, one long hold-off
  always @(negedge clk) begin
    if (!hold_done && n_accepted >= 120) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 15))
        0, 1: begin
          stall_left = int'($urandom_range(1, 12)) - 1;
          out_stall <= 1'b1;
        end
        2: begin
          calm_left = $urandom_range(20, 150);
          out_stall <= 1'b0;
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      pool.match_result({slot_index, out_x, out_y, glyph, alive, accepted, last});
  end

  initial begin
    int count;
    int guard;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty pool, grid corners, edge exits, saturation, odd periods
    send_cmd(scrambled_cmd(ppe_pkg::OP_CLEAR));
    send_cmd(tick_cmd('0));
    send_cmd(particle(16'sd0, 16'sd0, '0, '0, '0, '0, 8'h00, 8'hFF, 1'b0,
                      ppe_pkg::PERIOD_NEVER));
    send_cmd(particle(16'sh3FFF, 16'sh1FFF, '0, '0, '0, '0, 8'hFF, 8'h00, 1'b1, 21'sd1));
    send_cmd(particle(16'sd100, 16'sd100, '0, '0, '0, '0, 8'h55, 8'hAA, 1'b0, 21'sh100000));
    send_cmd(particle(16'sd8192, 16'sd4096, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                      8'h0F, 8'hF0, 1'b1, 21'sd1000));
    send_cmd(particle(16'sd0, 16'sd256, -16'sd1, '0, '0, '0, 8'h21, 8'h22, 1'b0, 21'sd5));
    send_cmd(particle(16'sd256, 16'sh1FFF, '0, 16'sd1, '0, '0, 8'h23, 8'h24, 1'b0, 21'sd5));
    send_cmd(particle(16'sh7FFF, 16'sd0, 16'sh7FFF, '0, '0, '0, 8'h25, 8'h26, 1'b1, 21'sd5));
    send_cmd(particle(16'sh8000, 16'sh7FFF, '0, '0, '0, '0, 8'h27, 8'h28, 1'b0, 21'sd5));
    send_cmd(particle(16'sd512, 16'sd512, 16'sd1, 16'sd1, '0, '0, 8'h31, 8'h32, 1'b0,
                      21'sh0FFFFF));
    send_cmd(particle(16'sd1024, 16'sd1024, '0, '0, '0, '0, 8'h41, 8'h42, 1'b1, '0));
    send_cmd(tick_cmd(20'hFFFFF));
    send_cmd(tick_cmd('0));
    send_cmd(tick_cmd(20'hFFFFF));
    send_cmd(scrambled_cmd(OP_UNKNOWN));
    send_cmd(tick_cmd(20'hFFFFF));
    send_cmd(tick_cmd(20'($urandom)));
    send_cmd(scrambled_cmd(ppe_pkg::OP_CLEAR));
    send_cmd(tick_cmd(20'd7));

    // random: fill the pool past full first, then mixed traffic
    count = 0;
    repeat (ppe_pkg::POOL_SLOTS + 2) begin
      send_cmd(drifting_insert());
      count++;
    end
    while (count < N_RANDOM) begin
      quiet = (count >= N_RANDOM - QUIET_TAIL);
      case ($urandom_range(0, 99)) inside
        [0:3]: begin
          send_cmd(scrambled_cmd(ppe_pkg::OP_CLEAR));
          count++;
        end
        [4:6]: send_cmd(scrambled_cmd(OP_UNKNOWN));
        [7:11]: begin
          repeat ($urandom_range(8, 36)) begin
            send_cmd(drifting_insert());
            count++;
          end
        end
        [12:54]: begin
          if ($urandom_range(0, 6) == 0) send_cmd(scrambled_cmd(ppe_pkg::OP_INSERT));
          else send_cmd(drifting_insert());
          count++;
        end
        default: begin
          send_cmd(random_tick());
          count++;
        end
      endcase
    end

    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (pool.slot_reports_due.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (ppe_pkg::POOL_SLOTS + 8) @(posedge clk);
    if (pool.slot_reports_due.size() != 0) begin
      $display("%0t: %0d results never arrived, expected slot %0d next", $time,
               pool.slot_reports_due.size(), pool.slot_reports_due[0].slot);
      pool.errors++;
    end
    if (pool.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ppe_pkg.sv
rtl/ppe_cell.sv
rtl/ppe_update.sv
rtl/particle_pool_engine_unit.sv
rtl/ppe_checker.sv
tb/testbench.sv
